[design/autorange_heatmap_colorizer_defines.svh]
// assertion macros used by the colorizer top level
`ifndef AUTORANGE_HEATMAP_COLORIZER_DEFINES_SVH
`define AUTORANGE_HEATMAP_COLORIZER_DEFINES_SVH

// plain property, checked every cycle out of reset
`define AHC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define AHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AHC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ahc_pkg.sv]
// shared types, constants and palette function of the heatmap colorizer
`default_nettype none

package ahc_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int PALETTE_SIZE     = 256;
    localparam int IDX_W            = $clog2(PALETTE_SIZE);
    localparam int CNT_W            = $clog2(IDX_W);
    localparam int COLOR_W          = 24;
    localparam int OUT_W            = COLOR_W + IDX_W;
    localparam int SMOOTH_W         = 17;
    localparam int FRAC_W           = 16;

    localparam logic [SMOOTH_W-1:0] SMOOTH_ONE = SMOOTH_W'(65536);
    localparam logic [SMOOTH_W-1:0] SMOOTH_RST = SMOOTH_W'(6554);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_OUT,
        S_MUL_HI,
        S_ADD_HI,
        S_MUL_LO,
        S_ADD_LO,
        S_SCALE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic out_load;
        logic mul_hi;
        logic add_hi;
        logic mul_lo;
        logic add_lo;
        logic scale_upd;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic last;
    } t_dp_sts;

    // {blue, green, red} of one palette entry
    function automatic logic [COLOR_W-1:0] palette_entry(input logic [IDX_W-1:0] k);
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [5:0] m;
        m = k[5:0];
        priority if (!k[7]) begin
            blue  = {1'b0, k[6:0]};
            green = 8'd0;
            red   = 8'd254 - {k[6:0], 1'b0};
        end else if (!k[6]) begin
            blue  = 8'd126 - {1'b0, m, 1'b0};
            green = {m, 2'b11};
            red   = 8'd0;
        end else begin
            blue  = 8'd0;
            green = 8'hff;
            red   = {m, 2'b11};
        end
        return {blue, green, red};
    endfunction

endpackage

`default_nettype wire

[design/autorange_heatmap_colorizer.sv]
// top level of the auto-ranging heatmap colorizer
//
//  port group     dir  payload (low bit first)                 end marker
//  s_axis         in   power_sample                            tlast = frame_end
//  m_axis         out  red, green, blue, color_index           tlast = frame_done
//  i_cfg_wr_*     in   smoothing_factor                        -
//
// an ordinary word goes through one load, one divider setup, 8 restoring-divider steps for the
// index bits and one output load before the next word can be accepted.
// a frame-end word adds two multiply/add pairs on the shared smoothing multiplier and one span
// update.
// the output load waits while the output register holds an untaken word.
// reset is synchronous: range 0, span 0, smoothing 6554, trackers cleared.
`default_nettype none

`include "autorange_heatmap_colorizer_defines.svh"

module autorange_heatmap_colorizer
    import ahc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [SMOOTH_W-1:0]    i_cfg_wr_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // power_sample, zero padded to whole bytes
    input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // red [7:0], green [15:8], blue [23:16], color_index [31:24]
    output logic [OUT_W-1:0]            m_axis_tdata,
    output logic                        m_axis_tlast
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    ahc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ahc_dp #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sample      ($signed(s_axis_tdata[SAMPLE_WIDTH-1:0])),
        .i_last        (s_axis_tlast),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_m_tready    (m_axis_tready),
        .o_m_tvalid    (m_axis_tvalid),
        .o_m_tdata     (m_axis_tdata),
        .o_m_tlast     (m_axis_tlast)
    );

    // only one word in flight
    `AHC_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "word accepted while another is in flight")
    // the output register is never overwritten while it holds an untaken word
    `AHC_ASSERT_IMP(a_out_room, i_clk, i_rst_n, w_cmd.out_load, w_sts.out_free, "output load without room")
    // the datapath gets at most one command per cycle
    `AHC_ASSERT(a_cmd_onehot, i_clk, i_rst_n, $onehot0(w_cmd), "overlapping datapath commands")

endmodule

`default_nettype wire

[design/ahc_ctrl.sv]
// sequencer for index division, output load and frame-end range update
`default_nettype none

module ahc_ctrl
    import ahc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(IDX_W - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = i_sts.last ? S_MUL_HI : S_IDLE;
                end
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_ADD_HI;
            end
            S_ADD_HI: begin
                o_cmd.add_hi = 1'b1;
                n_state      = S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_ADD_LO;
            end
            S_ADD_LO: begin
                o_cmd.add_lo = 1'b1;
                n_state      = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale_upd = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/ahc_dp.sv]
// range registers, restoring divider, smoothing multiplier and output register
`default_nettype none

module ahc_dp
    import ahc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [SMOOTH_W-1:0]            i_cfg_wr_data,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                           i_last,
    input  wire t_dp_cmd                        i_cmd,
    output t_dp_sts                             o_sts,
    input  wire logic                           i_m_tready,
    output logic                                o_m_tvalid,
    output logic [OUT_W-1:0]                    o_m_tdata,
    output logic                                o_m_tlast
);

    localparam int W      = SAMPLE_WIDTH;
    localparam int PROD_W = W + SMOOTH_W + 2;
    localparam logic signed [W-1:0] S_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] S_MIN = {1'b1, {(W-1){1'b0}}};

    logic [SMOOTH_W-1:0]        r_smooth;
    logic signed [W-1:0]        r_range_lo;
    logic signed [W-1:0]        r_range_hi;
    logic signed [W-1:0]        r_frame_lo;
    logic signed [W-1:0]        r_frame_hi;
    logic [W-1:0]               r_span;
    logic signed [W:0]          r_diff;
    logic                       r_last;
    logic [W-1:0]               r_rem;
    logic [IDX_W-1:0]           r_quot;
    logic                       r_run;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_out_valid;
    logic [OUT_W-1:0]           r_out_data;
    logic                       r_out_last;

    logic signed [W:0]          w_diff_in;
    logic                       w_zero;
    logic                       w_sat;
    logic [W:0]                 w_rem2;
    logic [W:0]                 w_rem_sub;
    logic                       w_ge;
    logic signed [W:0]          w_mul_d;
    logic signed [SMOOTH_W:0]   w_a;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [W-1:0]        w_step;
    logic                       w_out_free;

    assign w_diff_in = {i_sample[W-1], i_sample} - {r_range_lo[W-1], r_range_lo};

    // no positive offset or empty span gives index zero; offset at or past span saturates
    assign w_zero = (r_span == '0) || r_diff[W] || (r_diff == '0);
    assign w_sat  = !r_diff[W] && (r_diff[W-1:0] >= r_span);

    assign w_rem2    = {r_rem, 1'b0};
    assign w_rem_sub = w_rem2 - {1'b0, r_span};
    assign w_ge      = w_rem2 >= {1'b0, r_span};

    assign w_mul_d = i_cmd.mul_lo
                   ? {r_frame_lo[W-1], r_frame_lo} - {r_range_lo[W-1], r_range_lo}
                   : {r_frame_hi[W-1], r_frame_hi} - {r_range_hi[W-1], r_range_hi};
    assign w_a     = {1'b0, r_smooth};
    assign w_prod  = w_a * w_mul_d;
    // arithmetic shift keeps the floor toward minus infinity
    assign w_step  = r_prod[FRAC_W +: W];

    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth   <= SMOOTH_RST;
            r_range_lo <= '0;
            r_range_hi <= '0;
            r_frame_lo <= S_MAX;
            r_frame_hi <= S_MIN;
            r_span     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_smooth <= (i_cfg_wr_data > SMOOTH_ONE) ? SMOOTH_ONE : i_cfg_wr_data;
            end
            if (i_cmd.load) begin
                if (i_sample > r_frame_hi) begin
                    r_frame_hi <= i_sample;
                end
                if (i_sample < r_frame_lo) begin
                    r_frame_lo <= i_sample;
                end
            end
            if (i_cmd.add_hi) begin
                r_range_hi <= r_range_hi + w_step;
            end
            if (i_cmd.add_lo) begin
                r_range_lo <= r_range_lo + w_step;
            end
            if (i_cmd.scale_upd) begin
                r_span     <= (r_range_hi > r_range_lo) ? W'(r_range_hi - r_range_lo) : '0;
                r_frame_lo <= S_MAX;
                r_frame_hi <= S_MIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_diff <= w_diff_in;
            r_last <= i_last;
        end
        if (i_cmd.div_init) begin
            r_rem  <= r_diff[W-1:0];
            r_quot <= (!w_zero && w_sat) ? '1 : '0;
            r_run  <= !w_zero && !w_sat;
        end else if (i_cmd.div_step && r_run) begin
            r_rem  <= w_ge ? w_rem_sub[W-1:0] : w_rem2[W-1:0];
            r_quot <= {r_quot[IDX_W-2:0], w_ge};
        end
        if (i_cmd.mul_hi || i_cmd.mul_lo) begin
            r_prod <= w_prod;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {r_quot, palette_entry(r_quot)};
            r_out_last <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = w_out_free;
    assign o_sts.last     = r_last;
    assign o_m_tvalid     = r_out_valid;
    assign o_m_tdata      = r_out_data;
    assign o_m_tlast      = r_out_last;

endmodule

`default_nettype wire

[dv/autorange_heatmap_colorizer_checker.sv]
// checker for the heatmap colorizer: watches both streams, predicts each output word, compares
module autorange_heatmap_colorizer_checker
    import ahc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [SMOOTH_W-1:0] i_cfg_wr_data,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,   // power_sample
    input  logic                s_axis_tlast,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [OUT_W-1:0]    m_axis_tdata,   // red, green, blue, color_index
    input  logic                m_axis_tlast,
    output int                  o_mismatches,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] index;
        logic       done;
    } t_pixel;

    t_pixel             pixel_q[$];
    logic [COLOR_W-1:0] color_lut [PALETTE_SIZE];
    logic [SMOOTH_W-1:0] weight;
    logic signed [31:0] lo_range;
    logic signed [31:0] hi_range;
    logic signed [31:0] lo_seen;
    logic signed [31:0] hi_seen;
    logic [31:0]        span;

    // three fills over disjoint index ranges, later writes win: {blue, green, red}
    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        for (int i = 0; i < 256; i++)
            color_lut[i / 2] = {8'(i / 2), 8'd0, 8'(255 - i)};
        for (int i = 0; i < 256; i++)
            color_lut[(512 + i) / 4] = {8'(127 - i / 2), 8'(i), 8'd0};
        for (int i = 0; i < 256; i++)
            color_lut[(768 + i) / 4] = {8'd0, 8'd255, 8'(i)};
    end

    task automatic note_error(input string what);
        $display("ERROR at %0t ns: %s", $realtime, what);
        o_mismatches++;
    endtask

    // old + floor(a * (ext - old) / 2^16), floor toward minus infinity
    function automatic logic signed [31:0] glide(input logic signed [31:0] old,
                                                 input logic signed [31:0] ext,
                                                 input logic [SMOOTH_W-1:0] a);
        longint d;
        longint q;
        longint r;
        d = longint'(ext) - longint'(old);
        q = d >>> 16;
        r = d & 64'hFFFF;
        return 32'(longint'(old) + q * longint'(a) + ((longint'(a) * r) >>> 16));
    endfunction

    function automatic t_pixel colorize(input logic signed [31:0] x, input logic last);
        t_pixel px;
        longint lift;
        longint quot;
        logic [7:0] k;
        k    = 8'd0;
        lift = longint'(x) - longint'(lo_range);
        if (span != 32'd0 && lift > 0) begin
            quot = (lift * 256) / longint'(span);
            k    = (quot > 255) ? 8'd255 : 8'(quot);
        end
        px.red   = color_lut[k][7:0];
        px.green = color_lut[k][15:8];
        px.blue  = color_lut[k][23:16];
        px.index = k;
        px.done  = last;
        // current sample joins the trackers before the range moves
        if (x > hi_seen) hi_seen = x;
        if (x < lo_seen) lo_seen = x;
        if (last) begin
            hi_range = glide(hi_range, hi_seen, weight);
            lo_range = glide(lo_range, lo_seen, weight);
            span     = (hi_range > lo_range) ?
                       32'(longint'(hi_range) - longint'(lo_range)) : 32'd0;
            lo_seen  = 32'sh7FFF_FFFF;
            hi_seen  = 32'sh8000_0000;
        end
        return px;
    endfunction

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            weight   = SMOOTH_RST;
            lo_range = '0;
            hi_range = '0;
            lo_seen  = 32'sh7FFF_FFFF;
            hi_seen  = 32'sh8000_0000;
            span     = '0;
            pixel_q.delete();
        end else begin
            if (i_cfg_wr_en)
                weight = (i_cfg_wr_data > SMOOTH_ONE) ? SMOOTH_ONE : i_cfg_wr_data;
            if (m_axis_tvalid && m_axis_tready) begin
                if (pixel_q.size() == 0) begin
                    note_error($sformatf("unexpected output word %h", m_axis_tdata));
                end else begin
                    want = pixel_q.pop_front();
                    if (m_axis_tdata[7:0] !== want.red)
                        note_error($sformatf("red %0d, expected %0d",
                                             m_axis_tdata[7:0], want.red));
                    if (m_axis_tdata[15:8] !== want.green)
                        note_error($sformatf("green %0d, expected %0d",
                                             m_axis_tdata[15:8], want.green));
                    if (m_axis_tdata[23:16] !== want.blue)
                        note_error($sformatf("blue %0d, expected %0d",
                                             m_axis_tdata[23:16], want.blue));
                    if (m_axis_tdata[31:24] !== want.index)
                        note_error($sformatf("color_index %0d, expected %0d",
                                             m_axis_tdata[31:24], want.index));
                    if (m_axis_tlast !== want.done)
                        note_error($sformatf("frame_done %b, expected %b",
                                             m_axis_tlast, want.done));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pixel_q.push_back(colorize(s_axis_tdata, s_axis_tlast));
        end
        o_pending = pixel_q.size();
    end

endmodule

[dv/autorange_heatmap_colorizer_tb.sv]
// testbench top of the heatmap colorizer: stimulus, idling on both streams and the verdict
module autorange_heatmap_colorizer_tb
    import ahc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_WORDS = 185;
    localparam int SETTLE_CYC  = 24;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_wr_en   = 1'b0;
    logic [SMOOTH_W-1:0] i_cfg_wr_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [31:0]         s_axis_tdata  = '0;   // power_sample
    logic                s_axis_tlast  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b1;
    logic [OUT_W-1:0]    m_axis_tdata;         // red, green, blue, color_index
    logic                m_axis_tlast;

    int mismatches;
    int pending;
    bit idling = 1'b1;
    int quiet_cycles;

    logic [SMOOTH_W-1:0] phase_weights [8] = '{17'd32768, 17'd0, 17'd1, 17'd65535,
                                               17'd70000, 17'd0, 17'd6554, 17'd65536};

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    autorange_heatmap_colorizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    autorange_heatmap_colorizer_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // output side back-pressure in bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (idling && $urandom_range(0, 3) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
                m_axis_tready = 1'b1;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // ends the run if neither stream moves for too long
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // called and returns at a falling edge; valid stays up for the next word
    task automatic send_word(input logic [31:0] sample, input logic last);
        if (idling && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = sample;
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // drain, let any frame-end smoothing finish, then write the weight
    task automatic set_smoothing(input logic [SMOOTH_W-1:0] a);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = a;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    function automatic logic [31:0] pick_sample(input longint center, input int unsigned spread);
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return 32'(center + longint'($urandom_range(0, 2 * spread))
                                - longint'(spread));
        endcase
    endfunction

    // frames around one level with one spread, plus outliers and extremes
    task automatic run_phase(input int words);
        longint      center;
        int unsigned spread;
        int          sent;
        int          len;
        center = longint'(int'($urandom)) >>> $urandom_range(0, 16);
        spread = 32'd1 << $urandom_range(0, 28);
        sent   = 0;
        while (sent < words) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            for (int j = 0; j < len; j++)
                send_word(pick_sample(center, spread), j == len - 1);
            sent += len;
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty range after reset, reset weight, field extremes
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0001, 1'b1);
        // wide range now: below it, far above it, inside it
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0001_0000, 1'b1);

        // oversized weight saturates to 1.0, so the range lands on the frame extremes
        set_smoothing(17'h1_FFFF);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0100_0000, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0080_0000, 1'b0);
        send_word(32'h00FF_FFFF, 1'b0);
        send_word(32'h0100_0000, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h0001_0000, 1'b0);
        send_word(32'h0040_0000, 1'b1);
        // one-word frame collapses the range to zero width
        send_word(32'h1234_5678, 1'b1);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h1234_5678, 1'b1);

        phase_weights[5] = SMOOTH_W'($urandom_range(0, 17'h1_FFFF));
        foreach (phase_weights[p]) begin
            set_smoothing(phase_weights[p]);
            if (p == 7) idling = 1'b0;
            run_phase(PHASE_WORDS);
        end

        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/ahc_pkg.sv
design/ahc_ctrl.sv
design/ahc_dp.sv
design/autorange_heatmap_colorizer.sv
dv/autorange_heatmap_colorizer_checker.sv
dv/autorange_heatmap_colorizer_tb.sv
